// ===== rtl/cmdf_pkg.sv =====
// Package for the command message deframer: configuration and result-record
// types, register indexes, result codes and reset values. No dependencies.
`default_nettype none

package cmdf_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 128;
  localparam int unsigned NUM_COMMANDS_DEF = 64;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MASK_W  = 64;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned TALLY_W = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ABORT_CODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELIMITER_CODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_BASE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REGISTERED_MASK = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_ERROR   = 3'd6;

  // Reset values
  localparam logic [BYTE_W-1:0] ABORT_CODE_RST     = 8'd27;
  localparam logic [BYTE_W-1:0] ACK_CODE_RST       = 8'd19;
  localparam logic [BYTE_W-1:0] DELIMITER_CODE_RST = 8'd59;
  localparam logic [BYTE_W-1:0] START_CODE_RST     = 8'd18;
  localparam logic [BYTE_W-1:0] COMMAND_BASE_RST   = 8'd65;

  // Result codes
  localparam logic [1:0] EV_DISPATCH = 2'd0;
  localparam logic [1:0] EV_ERROR    = 2'd1;
  localparam logic [1:0] EV_REPLY    = 2'd2;
  localparam logic [1:0] EV_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] abort_code;
    logic [BYTE_W-1:0] ack_code;
    logic [BYTE_W-1:0] delimiter_code;
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] command_base;
    logic [MASK_W-1:0] registered_mask;
    logic              custom_error_enable;
  } cfg_t;

  // One queued result record; a reply expands into three transactions
  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] value_count;
  } desc_t;

endpackage

`default_nettype wire

// ===== rtl/cmdf_rx_if.sv =====
// Received-byte channel: valid/ready handshake with one byte of payload.
// Depends on nothing.
`default_nettype none

interface cmdf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/cmdf_res_if.sv =====
// Result channel: valid/ready handshake carrying one deframer result.
// Depends on nothing.
`default_nettype none

interface cmdf_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] command;
  logic [7:0] value_count;
  logic [7:0] reply_byte;
  logic       last;

  modport source (output valid, output event_res, output command, output value_count,
                  output reply_byte, output last, input ready);
  modport sink   (input valid, input event_res, input command, input value_count,
                  input reply_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/cmdf_collect.sv =====
// Message collector: tracks count, command byte and delimiter tally, and classifies
// finished messages and full-buffer drops into result records. Uses cmdf_pkg.
`default_nettype none

module cmdf_collect #(
  parameter int unsigned BUFFER_BYTES = cmdf_pkg::BUFFER_BYTES_DEF,
  parameter int unsigned NUM_COMMANDS = cmdf_pkg::NUM_COMMANDS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        fire,
  input  wire logic [cmdf_pkg::BYTE_W-1:0] rx_byte,
  input  wire cmdf_pkg::cfg_t              cfg,
  output logic                             push,
  output cmdf_pkg::desc_t                  desc
);

  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_BYTES);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [8:0] NUM_CMD9 = 9'(NUM_COMMANDS);
  localparam logic [cmdf_pkg::TALLY_W-1:0] TALLY_MAX = '1;

  logic [CNT_W-1:0]             byte_count, byte_count_next;
  logic [cmdf_pkg::BYTE_W-1:0]  first_byte, first_byte_next;
  logic [cmdf_pkg::TALLY_W-1:0] delimiter_tally, delimiter_tally_next;

  logic [8:0]                   diff;
  logic                         in_range;
  logic                         registered;
  logic [cmdf_pkg::BYTE_W-1:0]  cnt;

  always_comb begin
    diff       = {1'b0, first_byte} - {1'b0, cfg.command_base};
    // Borrow out means the command lies below the base
    in_range   = !diff[8] && (diff < NUM_CMD9);
    registered = cfg.registered_mask[diff[cmdf_pkg::SLOT_W-1:0]];
    cnt        = (byte_count == CNT_ONE) ? '0
               : cmdf_pkg::BYTE_W'({1'b0, delimiter_tally}) + 8'd1;
  end

  always_comb begin
    byte_count_next      = byte_count;
    first_byte_next      = first_byte;
    delimiter_tally_next = delimiter_tally;
    push                 = 1'b0;
    desc.kind            = cmdf_pkg::EV_OVERFLOW;
    desc.command         = first_byte;
    desc.value_count     = cnt;
    if (fire) begin
      priority if (rx_byte == cfg.abort_code) begin
        byte_count_next      = '0;
        first_byte_next      = '0;
        delimiter_tally_next = '0;
      end else if (rx_byte == cfg.ack_code) begin
        push = 1'b1;
        priority if (in_range && registered) begin
          desc.kind = cmdf_pkg::EV_DISPATCH;
        end else if (!in_range && cfg.custom_error_enable) begin
          desc.kind = cmdf_pkg::EV_ERROR;
        end else begin
          desc.kind = cmdf_pkg::EV_REPLY;
        end
        byte_count_next      = '0;
        first_byte_next      = '0;
        delimiter_tally_next = '0;
      end else if (byte_count < CNT_FULL) begin
        if (byte_count == '0) begin
          first_byte_next = rx_byte;
        end else if (rx_byte == cfg.delimiter_code && delimiter_tally != TALLY_MAX) begin
          delimiter_tally_next = delimiter_tally + 1'b1;
        end
        byte_count_next = byte_count + 1'b1;
      end else begin
        // Buffer full: drop the byte, keep the message
        push      = 1'b1;
        desc.kind = cmdf_pkg::EV_OVERFLOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      first_byte      <= '0;
      delimiter_tally <= '0;
    end else begin
      byte_count      <= byte_count_next;
      first_byte      <= first_byte_next;
      delimiter_tally <= delimiter_tally_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cmdf_emit.sv =====
// Result emitter: two-entry queue of result records, expanding a reply
// into start, command and ack bytes. Uses cmdf_pkg and cmdf_res_if.
`default_nettype none

module cmdf_emit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire cmdf_pkg::desc_t desc,
  input  wire cmdf_pkg::cfg_t  cfg,
  output logic                 full,
  cmdf_res_if.source           res
);

  cmdf_pkg::desc_t queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count, count_next;
  logic [1:0] beat;
  logic       pop;
  logic       head_last;
  cmdf_pkg::desc_t head;

  always_comb begin
    head      = queue[rd_ptr];
    head_last = (head.kind != cmdf_pkg::EV_REPLY) || (beat == 2'd2);
    res.valid = (count != 2'd0);
    pop       = res.valid && res.ready && head_last;
    full      = (count == 2'd2);

    res.event_res   = head.kind;
    res.last        = head_last;
    res.command     = '0;
    res.value_count = '0;
    res.reply_byte  = '0;
    unique case (head.kind)
      cmdf_pkg::EV_DISPATCH,
      cmdf_pkg::EV_ERROR: begin
        res.command     = head.command;
        res.value_count = head.value_count;
      end
      cmdf_pkg::EV_REPLY: begin
        unique case (beat)
          2'd0:    res.reply_byte = cfg.start_code;
          2'd1:    res.reply_byte = head.command;
          default: res.reply_byte = cfg.ack_code;
        endcase
      end
      default: ;
    endcase

    count_next = count + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
      beat   <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
        beat   <= '0;
      end else if (res.valid && res.ready) begin
        beat <= beat + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/command_message_deframer_unit.sv =====
// Top level of the command message deframer: configuration registers,
// collector and emitter. Uses cmdf_pkg, cmdf_rx_if, cmdf_res_if, cmdf_collect, cmdf_emit.
//
//   channel | modport      | payload                                          | accepted when
//   rx      | sink         | rx_byte[7:0]                                     | valid && ready
//   res     | source       | event_res, command, value_count, reply_byte, last| valid && ready
//   cfg     | write port   | cfg_index[2:0], cfg_data[63:0]                   | cfg_we
//
// One byte is taken per cycle while rx.ready is high; the message counters update at the
// accepting edge. A finished or overflowing byte queues one record in a two-entry queue,
// valid on the result side once it is at the head; a reply record leaves as three
// transactions, on consecutive cycles while res.ready holds, other records as one.
// rx.ready drops only while both queue entries are occupied, so a stalled result
// side holds at most two pending records. Synchronous reset clears counters,
// queue and registers to their default codes; no clearing pass is needed.
`default_nettype none

module command_message_deframer_unit #(
  parameter int unsigned BUFFER_BYTES = cmdf_pkg::BUFFER_BYTES_DEF,
  parameter int unsigned NUM_COMMANDS = cmdf_pkg::NUM_COMMANDS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [cmdf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cmdf_pkg::CFG_DATA_W-1:0]     cfg_data,
  cmdf_rx_if.sink                                  rx,
  cmdf_res_if.source                               res
);

  cmdf_pkg::cfg_t  cfg;
  cmdf_pkg::desc_t desc;
  logic            push;
  logic            full;
  logic            fire;

  assign rx.ready = !full;
  assign fire     = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.abort_code          <= cmdf_pkg::ABORT_CODE_RST;
      cfg.ack_code            <= cmdf_pkg::ACK_CODE_RST;
      cfg.delimiter_code      <= cmdf_pkg::DELIMITER_CODE_RST;
      cfg.start_code          <= cmdf_pkg::START_CODE_RST;
      cfg.command_base        <= cmdf_pkg::COMMAND_BASE_RST;
      cfg.registered_mask     <= '0;
      cfg.custom_error_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cmdf_pkg::REG_ABORT_CODE:      cfg.abort_code     <= cfg_data[7:0];
        cmdf_pkg::REG_ACK_CODE:        cfg.ack_code       <= cfg_data[7:0];
        cmdf_pkg::REG_DELIMITER_CODE:  cfg.delimiter_code <= cfg_data[7:0];
        cmdf_pkg::REG_START_CODE:      cfg.start_code     <= cfg_data[7:0];
        cmdf_pkg::REG_COMMAND_BASE:    cfg.command_base   <= cfg_data[7:0];
        cmdf_pkg::REG_REGISTERED_MASK: cfg.registered_mask <= cfg_data;
        cmdf_pkg::REG_CUSTOM_ERROR:    cfg.custom_error_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cmdf_collect #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .NUM_COMMANDS (NUM_COMMANDS)
  ) u_collect (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_byte (rx.rx_byte),
    .cfg     (cfg),
    .push    (push),
    .desc    (desc)
  );

  cmdf_emit u_emit (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .desc (desc),
    .cfg  (cfg),
    .full (full),
    .res  (res)
  );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for command_message_deframer_unit: drives received bytes
// and register writes, predicts every result and checks it on the result channel.
// Depends on cmdf_pkg, cmdf_rx_if, cmdf_res_if and the RTL of the deframer.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cmdf_pkg::*;

  localparam int unsigned RANDOM_BYTES = 470;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] command;
    logic [7:0] value_count;
    logic [7:0] reply_byte;
    logic       last;
  } frame_result_t;

  // Tracks the message being collected and holds the results it should cause
  class message_tracker;
    cfg_t               regs;
    logic [7:0]         stored;
    logic [7:0]         command_byte;
    logic [TALLY_W-1:0] tally;
    frame_result_t      pending[$];
    int                 mismatches;

    function new();
      regs.abort_code          = ABORT_CODE_RST;
      regs.ack_code            = ACK_CODE_RST;
      regs.delimiter_code      = DELIMITER_CODE_RST;
      regs.start_code          = START_CODE_RST;
      regs.command_base        = COMMAND_BASE_RST;
      regs.registered_mask     = '0;
      regs.custom_error_enable = 1'b0;
      mismatches = 0;
      clear_message();
    endfunction

    function void clear_message();
      stored       = '0;
      command_byte = '0;
      tally        = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ABORT_CODE:      regs.abort_code          = data[7:0];
        REG_ACK_CODE:        regs.ack_code            = data[7:0];
        REG_DELIMITER_CODE:  regs.delimiter_code      = data[7:0];
        REG_START_CODE:      regs.start_code          = data[7:0];
        REG_COMMAND_BASE:    regs.command_base        = data[7:0];
        REG_REGISTERED_MASK: regs.registered_mask     = data;
        REG_CUSTOM_ERROR:    regs.custom_error_enable = data[0];
        default: ;
      endcase
    endfunction

    function void push(logic [1:0] ev, logic [7:0] cmd, logic [7:0] cnt,
                       logic [7:0] rb, logic last);
      frame_result_t r;
      r.event_res   = ev;
      r.command     = cmd;
      r.value_count = cnt;
      r.reply_byte  = rb;
      r.last        = last;
      pending.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      logic [7:0]        cnt;
      logic [SLOT_W-1:0] slot;
      int                diff;
      logic              in_range;
      logic              hit;
      if (b == regs.abort_code) begin
        clear_message();
      end else if (b == regs.ack_code) begin
        cnt  = (stored == 8'd1) ? 8'd0 : 8'd1 + 8'(tally);
        diff = int'(command_byte) - int'(regs.command_base);
        slot = SLOT_W'(command_byte - regs.command_base);
        // below the base counts as out of range
        in_range = (diff >= 0) && (diff < int'(NUM_COMMANDS_DEF));
        hit = in_range && regs.registered_mask[slot];
        if (hit) begin
          push(EV_DISPATCH, command_byte, cnt, 8'd0, 1'b1);
        end else if (!in_range && regs.custom_error_enable) begin
          push(EV_ERROR, command_byte, cnt, 8'd0, 1'b1);
        end else begin
          push(EV_REPLY, 8'd0, 8'd0, regs.start_code, 1'b0);
          push(EV_REPLY, 8'd0, 8'd0, command_byte, 1'b0);
          push(EV_REPLY, 8'd0, 8'd0, regs.ack_code, 1'b1);
        end
        clear_message();
      end else if (stored < BUFFER_BYTES_DEF) begin
        if (stored == 8'd0) begin
          command_byte = b;
        end else if (b == regs.delimiter_code && tally != '1) begin
          tally++;
        end
        stored++;
      end else begin
        push(EV_OVERFLOW, 8'd0, 8'd0, 8'd0, 1'b1);
      end
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(frame_result_t got);
      frame_result_t want;
      if (pending.size() == 0) begin
        $error("result with no transaction pending: event_res %0d", got.event_res);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      check_field("event_res", 8'(want.event_res), 8'(got.event_res));
      check_field("command", want.command, got.command);
      check_field("value_count", want.value_count, got.value_count);
      check_field("reply_byte", want.reply_byte, got.reply_byte);
      check_field("last", 8'(want.last), 8'(got.last));
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cmdf_rx_if  rx_ch();
  cmdf_res_if res_ch();

  command_message_deframer_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_ch),
    .res       (res_ch)
  );

  message_tracker tracker = new();
  cfg_t           cfg;
  bit             quiet;
  int unsigned    sent_bytes;
  int unsigned    stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.abort_code     = pick_code();
    // occasionally let the abort code shadow the ack code
    c.ack_code       = ($urandom_range(0, 11) == 0) ? c.abort_code : pick_code();
    c.delimiter_code = pick_code();
    c.start_code     = pick_code();
    case ($urandom_range(0, 4))
      0: c.command_base = 8'h00;
      1: c.command_base = 8'hFF;
      default: c.command_base = 8'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: c.registered_mask = '1;
      1: c.registered_mask = '0;
      default: c.registered_mask = {$urandom, $urandom};
    endcase
    c.custom_error_enable = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic logic [7:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return cfg.command_base + 8'($urandom_range(0, 63));
    if (r < 65) return cfg.command_base - 8'd1;
    if (r < 75) return cfg.command_base + 8'd64;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_payload(int delim_pct);
    logic [7:0] b;
    if ($urandom_range(0, 99) < delim_pct) return cfg.delimiter_code;
    do b = 8'($urandom); while (b == cfg.abort_code || b == cfg.ack_code);
    return b;
  endfunction

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    sent_bytes++;
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    tracker.set_register(idx, data);
    @(posedge clk);
  endtask

  task automatic apply_config(cfg_t c);
    write_register(REG_ABORT_CODE, CFG_DATA_W'(c.abort_code));
    write_register(REG_ACK_CODE, CFG_DATA_W'(c.ack_code));
    write_register(REG_DELIMITER_CODE, CFG_DATA_W'(c.delimiter_code));
    write_register(REG_START_CODE, CFG_DATA_W'(c.start_code));
    write_register(REG_COMMAND_BASE, CFG_DATA_W'(c.command_base));
    write_register(REG_REGISTERED_MASK, c.registered_mask);
    write_register(REG_CUSTOM_ERROR, CFG_DATA_W'(c.custom_error_enable));
    cfg_we <= 1'b0;
    cfg = c;
  endtask

  // Hold the input side until every expected result has been taken
  task automatic drain();
    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Fill the buffer to or past its end, then finish the message
  task automatic send_long_message(bit all_delim);
    send_byte(pick_command());
    repeat ($urandom_range(127, 132))
      send_byte(all_delim ? cfg.delimiter_code : pick_payload(50));
    send_byte(cfg.ack_code);
  endtask

  task automatic send_random_chunk();
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 6) == 0) quiet = ~quiet;
    if (roll < 72) begin
      send_byte(pick_command());
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (n) send_byte(pick_payload(30));
      send_byte(cfg.ack_code);
    end else if (roll < 74) begin
      send_long_message(1'($urandom_range(0, 1)));
    end else if (roll < 86) begin
      send_byte(pick_command());
      repeat ($urandom_range(0, 5)) send_byte(pick_payload(30));
      send_byte(cfg.abort_code);
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end
  endtask

  initial begin
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rx_ch.valid && rx_ch.ready) tracker.take_byte(rx_ch.rx_byte);
      if (res_ch.valid && res_ch.ready)
        tracker.match_result({res_ch.event_res, res_ch.command, res_ch.value_count,
                              res_ch.reply_byte, res_ch.last});
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    cfg_t        c;
    int unsigned target;
    int unsigned phase_end;
    bit          first_phase;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    quiet      = 1'b0;
    sent_bytes = 0;
    cfg        = tracker.regs;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: empty message, command below base, unregistered command, abort
    send_byte(ACK_CODE_RST);
    send_byte(8'h00);
    send_byte(ACK_CODE_RST);
    send_byte(COMMAND_BASE_RST);
    send_byte(DELIMITER_CODE_RST);
    send_byte(DELIMITER_CODE_RST);
    send_byte(8'hFF);
    send_byte(ACK_CODE_RST);
    send_byte(8'h50);
    send_byte(ABORT_CODE_RST);
    send_byte(ACK_CODE_RST);
    drain();

    // Extreme codes: dispatch, custom errors, reply, abort mid-message
    c.abort_code          = 8'h00;
    c.ack_code            = 8'hFF;
    c.delimiter_code      = 8'h80;
    c.start_code          = 8'hFF;
    c.command_base        = 8'hC0;
    c.registered_mask     = 64'h8000_0000_0000_0001;
    c.custom_error_enable = 1'b1;
    apply_config(c);
    send_byte(8'hC0);
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFA);
    send_byte(8'hFF);
    send_byte(8'h0A);
    send_byte(8'hFF);
    send_byte(8'hC0);
    send_byte(8'h07);
    send_byte(8'h00);
    send_byte(8'hFF);
    drain();

    // Abort code equal to ack code: nothing ever finishes
    c.abort_code          = 8'h05;
    c.ack_code            = 8'h05;
    c.delimiter_code      = 8'hFF;
    c.start_code          = 8'h00;
    c.command_base        = 8'hFF;
    c.registered_mask     = '0;
    c.custom_error_enable = 1'b0;
    apply_config(c);
    send_byte(8'h00);
    send_byte(8'h05);
    send_byte(8'hFF);
    send_byte(8'h05);
    drain();

    target      = sent_bytes + RANDOM_BYTES;
    first_phase = 1'b1;
    while (sent_bytes < target) begin
      apply_config(random_settings());
      phase_end = sent_bytes + $urandom_range(50, 100);
      if (first_phase) send_long_message(1'b1);
      first_phase = 1'b0;
      while (sent_bytes < phase_end && sent_bytes < target) send_random_chunk();
      drain();
    end

    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
